FILE: rtl/core/mts_pkg.sv
// Shared types and codes for the minimum-tracking stack.
// Used by mts_stack_ram and min_tracking_stack; depends on nothing.
package mts_pkg;

    // Default number of entries on each stack
    localparam int unsigned DEFAULT_STACK_DEPTH = 256;

    // Width of one stored value
    localparam int unsigned DATA_W = 32;

    // Width of the reported element count
    localparam int unsigned DEPTH_OUT_W = 9;

    // Action codes carried in the input tuser
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;

    // Status codes carried in the output tuser
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Sequencer states
    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } t_state;

endpackage

FILE: rtl/core/mts_stack_ram.sv
// Simple dual-port stack storage: one write port, one registered read port.
// Depends on mts_pkg for the data width.
module mts_stack_ram #(
    parameter int unsigned DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [mts_pkg::DATA_W-1:0]       i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [mts_pkg::DATA_W-1:0]       o_rdata
);
    import mts_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write the entry on request
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/min_tracking_stack.sv
// Top level of the minimum-tracking stack: value stack and minimum stack
// in two mts_stack_ram instances, tops cached in registers. Uses mts_pkg.
//
//  channel   dir  tdata                                   tuser
//  s_axis    in   push_value[31:0]                        action[1:0]
//  m_axis    out  top[31:0] min[63:32] depth[72:64]       status[1:0]
//                 is_empty[73], zero pad to 80 bits
//
// Push, peek and faulted pops load the result from S_IDLE; a valid pop passes
// through S_READ, since the new tops come back from the registered memory reads.
// Reset clears both counts; stored entries need no clearing.
// A result waits in the output register while the master stalls; the next
// beat is taken in the same cycle that register drains.
module min_tracking_stack #(
    parameter int unsigned STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis: tdata = push_value; tuser = action
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    // m_axis: tdata = top_value, min_value, depth_now, is_empty, zero pad
    //         tuser = status
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser
);
    import mts_pkg::*;

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_mcount, n_mcount;
    logic [DATA_W-1:0]  r_top, n_top;
    logic [DATA_W-1:0]  r_mtop, n_mtop;
    logic               r_min_pop, n_min_pop;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_out_top, n_out_top;
    logic [DATA_W-1:0]  r_out_min, n_out_min;
    logic [DEPTH_OUT_W-1:0] r_out_depth, n_out_depth;
    logic               r_out_empty, n_out_empty;
    logic [1:0]         r_out_status, n_out_status;

    logic               accept;
    logic               full;
    logic               min_full;
    logic               min_take;
    logic               load_out;
    logic [1:0]         status_w;
    logic [DATA_W-1:0]  push_val;
    logic               v_we, m_we;
    logic [AW-1:0]      v_raddr, m_raddr;
    logic [DATA_W-1:0]  v_rdata, m_rdata;

    assign push_val = s_axis_tdata;
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign min_full = (r_mcount == CW'(STACK_DEPTH));
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept   = s_axis_tvalid && s_axis_tready;

    // New value joins the minimum stack when that stack is empty or it is not larger
    assign min_take = (r_mcount == '0) || ($signed(push_val) <= $signed(r_mtop));

    // Memory writes on a push that fits
    assign v_we = accept && (s_axis_tuser == ACT_PUSH) && !full;
    assign m_we = v_we && min_take && !min_full;

    // Read the entries under the tops, used only after a valid pop
    assign v_raddr = AW'(r_count - CW'(2));
    assign m_raddr = AW'(r_mcount - CW'(2));

    mts_stack_ram #(.DEPTH(STACK_DEPTH)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (push_val),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    mts_stack_ram #(.DEPTH(STACK_DEPTH)) u_minimum_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (r_mcount[AW-1:0]),
        .i_wdata (push_val),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // Next state, stack update and result build
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_mcount     = r_mcount;
        n_top        = r_top;
        n_mtop       = r_mtop;
        n_min_pop    = r_min_pop;
        n_out_valid  = r_out_valid && !m_axis_tready;
        load_out     = 1'b0;
        status_w     = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (s_axis_tuser)
                        ACT_PUSH: begin
                            load_out = 1'b1;
                            if (full) begin
                                status_w = ST_OVERFLOW;
                            end else begin
                                n_count = r_count + CW'(1);
                                n_top   = push_val;
                                if (min_take && !min_full) begin
                                    n_mcount = r_mcount + CW'(1);
                                    n_mtop   = push_val;
                                end
                            end
                        end
                        ACT_POP: begin
                            if (r_count == '0) begin
                                load_out = 1'b1;
                                status_w = ST_UNDERFLOW;
                            end else begin
                                n_count   = r_count - CW'(1);
                                n_min_pop = (r_mcount != '0) && (r_top == r_mtop);
                                if (n_min_pop) begin
                                    n_mcount = r_mcount - CW'(1);
                                end
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                // Pick up the new tops from the memories
                n_top = v_rdata;
                if (r_min_pop) begin
                    n_mtop = m_rdata;
                end
                load_out = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_top    = r_out_top;
        n_out_min    = r_out_min;
        n_out_depth  = r_out_depth;
        n_out_empty  = r_out_empty;
        n_out_status = r_out_status;
        if (load_out) begin
            n_out_valid  = 1'b1;
            n_out_top    = (n_count != '0) ? n_top : '0;
            n_out_min    = ((n_count != '0) && (n_mcount != '0)) ? n_mtop : '0;
            n_out_depth  = DEPTH_OUT_W'(n_count);
            n_out_empty  = (n_count == '0);
            n_out_status = status_w;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mcount    <= n_mcount;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_mtop       <= n_mtop;
        r_min_pop    <= n_min_pop;
        r_out_top    <= n_out_top;
        r_out_min    <= n_out_min;
        r_out_depth  <= n_out_depth;
        r_out_empty  <= n_out_empty;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_empty, r_out_depth, r_out_min, r_out_top};
    assign m_axis_tuser  = r_out_status;

    // Counts stay within the storage
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(STACK_DEPTH)) && (r_mcount <= r_count))
        else $error("stack count out of range");

    // A pop in flight never finds a result still waiting
    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("output register busy during pop read");

    // A valid pop always lowers the count by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (s_axis_tuser == ACT_POP) && (r_count != '0))
        |=> (r_state == S_READ) && (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not lower the count");

    // Minimum stack is empty exactly when the value stack is
    a_min_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_mcount == '0))
        else $error("minimum stack out of step with value stack");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for min_tracking_stack: directed table, random traffic and a fill-and-drain pass.
// Depends on mts_pkg and min_tracking_stack; expected beats come from a predictor or typed rows.
`timescale 1ns / 1ps

module testbench;
    import mts_pkg::*;

    localparam int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH;
    // Action code left unassigned; the block treats it as a peek
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int unsigned IDLE_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 400;
    // Depth at which the drain after the overflow check stops
    localparam int unsigned DRAIN_FLOOR = STACK_DEPTH * 5 / 8;

    typedef struct packed {
        logic signed [31:0] top;
        logic signed [31:0] min;
        logic [8:0]         depth;
        logic               empty;
        logic [1:0]         status;
    } t_result;

    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] val;
        logic        typed;
        t_result     want;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // push_value[31:0]
    logic [1:0]  s_axis_tuser = '0;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;        // top[31:0] min[63:32] depth[72:64] is_empty[73] pad
    logic [1:0]  m_axis_tuser;        // status[1:0]

    // Predictor state: both stacks and their counts
    logic signed [31:0] value_stack [STACK_DEPTH];
    logic signed [31:0] min_stack [STACK_DEPTH];
    int unsigned        held_count = 0;
    int unsigned        min_count = 0;

    t_result     expected_results [$];
    t_stim       directed_rows [$];
    int unsigned error_count = 0;
    int unsigned results_seen = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;

    min_tracking_stack #(.STACK_DEPTH(STACK_DEPTH)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Apply one action to the stack copy and return the beat it should produce
    function automatic t_result predict_stack_result(input logic [1:0] act,
                                                     input logic signed [31:0] val);
        t_result            r;
        logic signed [31:0] popped;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_PUSH: begin
                if (held_count >= STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    value_stack[held_count] = val;
                    held_count++;
                    if (min_count == 0 || val <= min_stack[min_count - 1]) begin
                        min_stack[min_count] = val;
                        min_count++;
                    end
                end
            end
            ACT_POP: begin
                if (held_count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    popped = value_stack[held_count - 1];
                    if (min_count > 0 && popped == min_stack[min_count - 1])
                        min_count--;
                    held_count--;
                end
            end
            default: ;
        endcase
        if (held_count > 0)
            r.top = value_stack[held_count - 1];
        if (held_count > 0 && min_count > 0)
            r.min = min_stack[min_count - 1];
        r.depth = 9'(held_count);
        r.empty = (held_count == 0);
        return r;
    endfunction

    function automatic t_stim stim_row(input logic [1:0] act, input logic [31:0] val);
        t_stim s;
        s = '0;
        s.act = act;
        s.val = val;
        return s;
    endfunction

    function automatic t_stim typed_row(input logic [1:0] act, input logic [31:0] val,
                                        input logic [31:0] top, input logic [31:0] min,
                                        input logic [8:0] depth, input logic [1:0] status);
        t_stim s;
        s = stim_row(act, val);
        s.typed = 1'b1;
        s.want.top = top;
        s.want.min = min;
        s.want.depth = depth;
        s.want.empty = (depth == 0);
        s.want.status = status;
        return s;
    endfunction

    // Append one row to the directed table
    task automatic add_row(input t_stim s);
        directed_rows.insert(directed_rows.size(), s);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got,
                 want);
    endtask

    // Offer one beat in bursts separated by random gaps; queue its result on acceptance
    task automatic send_item(input logic [1:0] act, input logic [31:0] val, input logic typed,
                             input t_result typed_want);
        int unsigned gap;
        t_result     predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= val;
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_stack_result(act, val);
        expected_results.insert(expected_results.size(), typed ? typed_want : predicted);
    endtask

    task automatic send_op(input logic [1:0] act, input logic [31:0] val);
        send_item(act, val, 1'b0, '0);
    endtask

    // Extremes, small values that repeat often, and full-range values
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2, 3, 4: v = 32'($urandom_range(0, 16)) - 32'd8;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pick_action(input int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) return ACT_PEEK;
        if (r < 6) return ACT_SPARE;
        if (r < 6 + push_pct) return ACT_PUSH;
        return ACT_POP;
    endfunction

    // Mixed traffic; the push/pop balance is redrawn every 40 beats
    task automatic run_random(input int unsigned count);
        int unsigned push_pct;
        push_pct = 47;
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 70;
                    1: push_pct = 25;
                    default: push_pct = 47;
                endcase
            end
            send_op(pick_action(push_pct), pick_value());
        end
    endtask

    // Fill to capacity with a partly falling sequence, overflow, then drain part of it
    task automatic fill_and_drain();
        logic [31:0] falling;
        falling = 32'd10000;
        while (held_count < STACK_DEPTH) begin
            if ($urandom_range(0, 1) == 0) begin
                falling = falling - 32'($urandom_range(0, 2));
                send_op(ACT_PUSH, falling);
            end else begin
                send_op(ACT_PUSH, pick_value());
            end
        end
        repeat (3) send_op(ACT_PUSH, pick_value());
        send_op(ACT_PEEK, pick_value());
        while (held_count > DRAIN_FLOOR)
            send_op(($urandom_range(0, 15) == 0) ? ACT_PEEK : ACT_POP, pick_value());
        repeat (2) send_op(ACT_POP, pick_value());
    endtask

    // Stimulus and end of run
    initial begin
        add_row(typed_row(ACT_PEEK, 32'h0, 32'h0, 32'h0, 9'd0, ST_OK));
        add_row(typed_row(ACT_POP, 32'h0, 32'h0, 32'h0, 9'd0, ST_UNDERFLOW));
        add_row(typed_row(ACT_SPARE, 32'hFFFF_FFFF, 32'h0, 32'h0, 9'd0, ST_OK));
        add_row(typed_row(ACT_PUSH, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 9'd1, ST_OK));
        add_row(typed_row(ACT_POP, 32'h1234_5678, 32'h0, 32'h0, 9'd0, ST_OK));
        add_row(typed_row(ACT_POP, 32'h0, 32'h0, 32'h0, 9'd0, ST_UNDERFLOW));
        add_row(typed_row(ACT_PUSH, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 9'd1, ST_OK));
        add_row(typed_row(ACT_PUSH, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 9'd2, ST_OK));
        add_row(stim_row(ACT_PUSH, 32'h8000_0000));
        add_row(stim_row(ACT_PUSH, 32'h0000_0000));
        add_row(stim_row(ACT_PUSH, 32'hFFFF_FFFF));
        add_row(stim_row(ACT_PEEK, 32'hAAAA_AAAA));
        add_row(stim_row(ACT_POP, 32'h0));
        add_row(stim_row(ACT_POP, 32'h0));
        add_row(stim_row(ACT_POP, 32'h0));
        add_row(stim_row(ACT_PEEK, 32'h0));
        add_row(stim_row(ACT_POP, 32'h0));
        add_row(stim_row(ACT_PUSH, 32'd5));
        add_row(stim_row(ACT_PUSH, 32'd5));
        add_row(stim_row(ACT_PUSH, 32'd3));
        add_row(stim_row(ACT_POP, 32'h0));
        add_row(stim_row(ACT_POP, 32'h0));
        add_row(stim_row(ACT_POP, 32'h0));
        add_row(stim_row(ACT_SPARE, 32'h5555_5555));
        add_row(stim_row(ACT_POP, 32'h0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].act, directed_rows[i].val, directed_rows[i].typed,
                      directed_rows[i].want);
        run_random(30);
        fill_and_drain();
        run_random(30);
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then allow stray beats to show up
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Result side: alternate stall patterns, plus one long hold-off to back up the input
    initial begin : result_stall
        int unsigned cycle_count;
        int unsigned hold_left;
        int unsigned mode;
        logic        hold_done;
        cycle_count = 0;
        hold_left = 0;
        mode = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && results_seen >= 120) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= (cycle_count % 3 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat (top)", m_axis_tdata[31:0], 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[31:0] !== want.top)
                    report_mismatch("top_value", m_axis_tdata[31:0], want.top);
                if (m_axis_tdata[63:32] !== want.min)
                    report_mismatch("min_value", m_axis_tdata[63:32], want.min);
                if (m_axis_tdata[72:64] !== want.depth)
                    report_mismatch("depth_now", 32'(m_axis_tdata[72:64]), 32'(want.depth));
                if (m_axis_tdata[73] !== want.empty)
                    report_mismatch("is_empty", 32'(m_axis_tdata[73]), 32'(want.empty));
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
            end
        end
    end

    // Stop the run if neither side moves a beat for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: filelist.f
rtl/core/mts_pkg.sv
rtl/core/mts_stack_ram.sv
rtl/core/min_tracking_stack.sv
verif/testbench.sv
